// ----- sv/wtse_pkg.sv -----
package wtse_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int BANKS        = 8;
    localparam int WORDS        = SECTOR_BYTES / BANKS;
    localparam int PTR_W        = $clog2(SECTOR_BYTES);
    localparam int ROW_W        = $clog2(WORDS);
    localparam int BANK_W       = $clog2(BANKS);

    localparam int QDEPTH  = 4;
    localparam int Q_IDX_W = $clog2(QDEPTH);
    localparam int Q_CNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CRC_MARK  = 8'hF7;
    localparam logic       REQ_START = 1'b0;
    localparam logic       REQ_DATA  = 1'b1;

    typedef enum logic {
        CMD_WRITE,
        CMD_FLUSH
    } cmd_kind_t;

    // One command for the back end: a byte write, or a sector flush that
    // starts reading at ptr with the tags captured at the marker.
    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       data_byte;
        logic [PTR_W-1:0] ptr;
        logic [7:0]       track;
        logic             side;
        logic [7:0]       sector;
    } cmd_t;

endpackage

// ----- sv/wtse_front.sv -----
module wtse_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_req_type,
    input  logic [7:0]      s_track_no,
    input  logic            s_side_no,
    input  logic [7:0]      s_data_byte,
    input  logic            clearing,
    input  logic            q_full,
    output logic            q_push,
    output wtse_pkg::cmd_t  q_cmd
);
    import wtse_pkg::*;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [7:0]       track_reg, track_next;
    logic             side_reg, side_next;
    logic [7:0]       sector_reg, sector_next;
    logic             parity_reg, parity_next;
    logic             accept;
    logic [PTR_W-1:0] wp_inc;

    assign s_ready = !q_full && !clearing;
    assign accept  = s_valid && s_ready;
    assign wp_inc  = (wp_reg == PTR_W'(SECTOR_BYTES - 1)) ? '0 : wp_reg + PTR_W'(1);

    always_comb begin
        wp_next     = wp_reg;
        track_next  = track_reg;
        side_next   = side_reg;
        sector_next = sector_reg;
        parity_next = parity_reg;
        q_push      = 1'b0;
        q_cmd.kind      = CMD_WRITE;
        q_cmd.data_byte = s_data_byte;
        q_cmd.ptr       = wp_reg;
        q_cmd.track     = track_reg;
        q_cmd.side      = side_reg;
        q_cmd.sector    = sector_reg;
        if (accept) begin
            if (s_req_type == REQ_START) begin
                wp_next     = '0;
                track_next  = s_track_no;
                side_next   = s_side_no;
                sector_next = 8'd1;
                parity_next = 1'b0;
            end else if (s_data_byte != CRC_MARK) begin
                q_push  = 1'b1;
                wp_next = wp_inc;
            end else begin
                // The second marker of a pair closes the data field.
                if (parity_reg) begin
                    q_push      = 1'b1;
                    q_cmd.kind  = CMD_FLUSH;
                    sector_next = sector_reg + 8'd1;
                end
                parity_next = !parity_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            track_reg  <= '0;
            side_reg   <= 1'b0;
            sector_reg <= 8'd1;
            parity_reg <= 1'b0;
        end else begin
            wp_reg     <= wp_next;
            track_reg  <= track_next;
            side_reg   <= side_next;
            sector_reg <= sector_next;
            parity_reg <= parity_next;
        end
    end

endmodule

// ----- sv/wtse_queue.sv -----
module wtse_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wtse_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output wtse_pkg::cmd_t  head_cmd
);
    import wtse_pkg::*;

    cmd_t               q_mem_reg [QDEPTH];
    logic [Q_IDX_W-1:0] wr_idx_reg, rd_idx_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == Q_CNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = q_mem_reg[rd_idx_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_idx_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_idx_reg <= (wr_idx_reg == Q_IDX_W'(QDEPTH - 1)) ? '0
                                                                   : wr_idx_reg + Q_IDX_W'(1);
            end
            if (pop) begin
                rd_idx_reg <= (rd_idx_reg == Q_IDX_W'(QDEPTH - 1)) ? '0
                                                                   : rd_idx_reg + Q_IDX_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/wtse_back.sv -----
module wtse_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  wtse_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            clearing,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_track,
    output logic            m_out_side,
    output logic [7:0]      m_out_sector,
    output logic [5:0]      m_word_index,
    output logic [63:0]     m_sector_word,
    output logic            m_last_word
);
    import wtse_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_OUT
    } state_t;

    state_t            state_reg;
    logic [ROW_W-1:0]  clr_row_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [BANK_W-1:0] off_reg;
    logic [ROW_W-1:0]  word_cnt_reg;
    logic              m_valid_reg;
    logic [7:0]        track_reg;
    logic              side_reg;
    logic [7:0]        sector_reg;
    logic [63:0]       word_reg;

    // The ring is split into byte banks so that one word at any byte
    // offset reads every bank exactly once.
    logic [7:0]        ring_mem [BANKS][WORDS];
    logic [7:0]        rdata_reg [BANKS];
    logic [ROW_W-1:0]  raddr [BANKS];
    logic [BANKS-1:0]  bank_we;
    logic [ROW_W-1:0]  waddr;
    logic [7:0]        wdata;
    logic              do_write;

    assign clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign do_write = q_pop && (q_cmd.kind == CMD_WRITE);
    assign row_next = (row_reg == ROW_W'(WORDS - 1)) ? '0 : row_reg + ROW_W'(1);
    assign waddr    = clearing ? clr_row_reg : q_cmd.ptr[PTR_W-1:BANK_W];
    assign wdata    = clearing ? 8'd0 : q_cmd.data_byte;

    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            bank_we[BANK_W'(b)] = clearing ||
                                  (do_write && (q_cmd.ptr[BANK_W-1:0] == BANK_W'(b)));
            // Banks below the start offset hold the tail of the word one row on.
            raddr[BANK_W'(b)]   = (BANK_W'(b) >= off_reg) ? row_reg : row_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < BANKS; b++) begin
            if (bank_we[BANK_W'(b)]) begin
                ring_mem[BANK_W'(b)][waddr] <= wdata;
            end
            rdata_reg[BANK_W'(b)] <= ring_mem[BANK_W'(b)][raddr[BANK_W'(b)]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_row_reg <= clr_row_reg + ROW_W'(1);
                    if (clr_row_reg == ROW_W'(WORDS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid && q_cmd.kind == CMD_FLUSH) begin
                        row_reg      <= q_cmd.ptr[PTR_W-1:BANK_W];
                        off_reg      <= q_cmd.ptr[BANK_W-1:0];
                        word_cnt_reg <= '0;
                        track_reg    <= q_cmd.track;
                        side_reg     <= q_cmd.side;
                        sector_reg   <= q_cmd.sector;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    for (int j = 0; j < BANKS; j++) begin
                        word_reg[8*j +: 8] <= rdata_reg[BANK_W'(off_reg + BANK_W'(j))];
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (word_cnt_reg == ROW_W'(WORDS - 1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            word_cnt_reg <= word_cnt_reg + ROW_W'(1);
                            row_reg      <= row_next;
                            state_reg    <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_track   = track_reg;
    assign m_out_side    = side_reg;
    assign m_out_sector  = sector_reg;
    assign m_word_index  = 6'(word_cnt_reg);
    assign m_sector_word = word_reg;
    assign m_last_word   = (word_cnt_reg == ROW_W'(WORDS - 1));

endmodule

// ----- sv/write_track_sector_extractor_unit.sv -----
// Channel | Handshake          | Payload
// --------+--------------------+--------------------------------------------------
// input   | s_valid / s_ready  | s_req_type, s_track_no, s_side_no, s_data_byte
// result  | m_valid / m_ready  | m_out_track, m_out_side, m_out_sector,
//         |                    | m_word_index, m_sector_word, m_last_word
//
// After reset the ring is zeroed one row of eight bytes per cycle, all 64 rows,
// with s_ready low. An input transaction is taken while the four-entry command
// queue has room; a byte write leaves the queue when the back end is idle.
// A sector flush leaves the queue, then each word passes through bank read, byte
// rotate and output register, which do not overlap, before the next word is begun.
// A stalled m_ready holds the flush; input keeps flowing until the queue fills.
module write_track_sector_extractor_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_track_no,
    input  logic        s_side_no,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_track,
    output logic        m_out_side,
    output logic [7:0]  m_out_sector,
    output logic [5:0]  m_word_index,
    output logic [63:0] m_sector_word,
    output logic        m_last_word
);
    import wtse_pkg::*;

    logic clearing;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    wtse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_track_no  (s_track_no),
        .s_side_no   (s_side_no),
        .s_data_byte (s_data_byte),
        .clearing    (clearing),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    wtse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    wtse_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_track   (m_out_track),
        .m_out_side    (m_out_side),
        .m_out_sector  (m_out_sector),
        .m_word_index  (m_word_index),
        .m_sector_word (m_sector_word),
        .m_last_word   (m_last_word)
    );

endmodule

// ----- sv/wtse_checker.sv -----
module wtse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_track,
    input logic        m_out_side,
    input logic [7:0]  m_out_sector,
    input logic [5:0]  m_word_index,
    input logic [63:0] m_sector_word,
    input logic        m_last_word
);

    // A result transaction that is not taken holds its payload.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sector_word) && $stable(m_word_index))
        else $error("result payload changed while stalled");

    // The last word of a sector is word 63.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_word |-> m_word_index == 6'd63)
        else $error("last word flagged at wrong index");

    // Tags stay the same between words of one sector.
    a_tags_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=>
            $stable(m_out_sector) && $stable(m_out_track) && $stable(m_out_side))
        else $error("sector tags changed inside a sector");

    // Right after reset the ring is being cleared: nothing taken, nothing shown.
    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready && !m_valid)
        else $error("block active right after reset");

endmodule

bind write_track_sector_extractor_unit wtse_checker u_wtse_checker (.*);
